/* hw/rtl/sorted_key_bracket_interpolator_defines.svh */
// Assertion macros shared by the bracket interpolator RTL.
// Uses the enclosing module's clk and rst; no other dependencies.
`ifndef SORTED_KEY_BRACKET_INTERPOLATOR_DEFINES_SVH
`define SORTED_KEY_BRACKET_INTERPOLATOR_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SKBI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SKBI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SKBI_ASSERT(lbl, prop, msg)
`define SKBI_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

/* hw/rtl/skbi_pkg.sv */
// Shared types and constants for the sorted key bracket interpolator.
// No dependencies; used by every module of the block.
`default_nettype none
package skbi_pkg;

  localparam int KEY_W     = 16;
  localparam int DUR_W     = 16;
  localparam int FRAC_W    = 16;
  localparam int IDX_OUT_W = 4;
  localparam int CNT_OUT_W = 5;
  localparam int STATUS_W  = 2;
  localparam int DIV_CNT_W = 5;

  localparam logic [DIV_CNT_W-1:0] DIV_STEPS = 5'd16;
  localparam logic [FRAC_W-1:0]    FRAC_MAX  = 16'hFFFF;

  localparam logic CMD_QUERY  = 1'b0;
  localparam logic CMD_INSERT = 1'b1;

  localparam logic [STATUS_W-1:0] ST_QUERY_DONE = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INSERTED   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL_DROP  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_IGNORED    = 2'd3;

  // One table entry: the key and the duration live in the same memory word.
  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [DUR_W-1:0]        dur;
  } entry_t;

  typedef struct packed {
    logic              start;
    logic [FRAC_W-1:0] num;
    logic [FRAC_W-1:0] den;
  } div_req_t;

endpackage
`default_nettype wire

/* hw/rtl/skbi_mem.sv */
// Sample table memory: one write port, one read port, registered read data.
// Depends on skbi_pkg for the entry type.
`default_nettype none
module skbi_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [AW-1:0]        wa,
  input  wire skbi_pkg::entry_t     wd,
  input  wire logic [AW-1:0]        ra,
  output skbi_pkg::entry_t          rd
);
  import skbi_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    rd <= mem[ra];
  end

endmodule
`default_nettype wire

/* hw/rtl/skbi_div.sv */
// Restoring divider for the Q0.16 fraction, one quotient bit per cycle.
// Depends on skbi_pkg for the request type and widths.
`default_nettype none
module skbi_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire skbi_pkg::div_req_t            req,
  output logic                               done,
  output logic [skbi_pkg::FRAC_W-1:0]        quot
);
  import skbi_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [FRAC_W-1:0]    rem;
  logic [FRAC_W-1:0]    den;
  logic [FRAC_W:0]      trial;
  logic [FRAC_W:0]      trial_sub;
  logic                 fits;

  always_comb begin
    trial     = {rem, 1'b0};
    trial_sub = trial - {1'b0, den};
    fits      = trial >= {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        den <= req.den;
        // A zero span gives zero; the key sitting on the upper key saturates.
        if (req.den == '0) begin
          quot <= '0;
          done <= 1'b1;
        end else if (req.num >= req.den) begin
          quot <= FRAC_MAX;
          done <= 1'b1;
        end else begin
          rem  <= req.num;
          quot <= '0;
          cnt  <= DIV_STEPS;
          busy <= 1'b1;
        end
      end else if (busy) begin
        if (fits) begin
          rem  <= trial_sub[FRAC_W-1:0];
          quot <= {quot[FRAC_W-2:0], 1'b1};
        end else begin
          rem  <= trial[FRAC_W-1:0];
          quot <= {quot[FRAC_W-2:0], 1'b0};
        end
        cnt <= cnt - DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/sorted_key_bracket_interpolator.sv */
// Sorted key bracket interpolator. The block holds up to SLOTS samples
// (signed Q8.8 key, Q8.8 duration) sorted by key in a single-port-read sample
// memory, and handles one item at a time, giving exactly one result item per
// input item. An ignored insert, a dropped insert, a query on an empty table and
// an insert into an empty table go from dispatch straight to the result register;
// any other insert walks down from the top entry, moving one entry up per cycle
// until it finds a smaller key. A query is checked against the first entry and
// then the last, and is clamped at either one; an interior key scans one entry per
// cycle up to its bracket and then runs a 16-step divider, whose steps are skipped
// when the key equals the upper key, and a multiply-add. The next item is accepted
// in the cycle after the result register is loaded, even while that result still
// waits to be taken; a stalled result delays the loading of the following one.
// Depends on skbi_pkg, skbi_mem, skbi_div and the assertion macro header.
`default_nettype none
`include "sorted_key_bracket_interpolator_defines.svh"
module sorted_key_bracket_interpolator #(
  parameter int SLOTS = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic                               command,
  input  wire logic signed [skbi_pkg::KEY_W-1:0]  key,
  input  wire logic [skbi_pkg::DUR_W-1:0]         sample_duration,
  input  wire logic                               sample_present,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [skbi_pkg::IDX_OUT_W-1:0]          index_low,
  output logic [skbi_pkg::IDX_OUT_W-1:0]          index_high,
  output logic [skbi_pkg::FRAC_W-1:0]             fraction,
  output logic [skbi_pkg::DUR_W-1:0]              blended_duration,
  output logic [skbi_pkg::CNT_OUT_W-1:0]          entry_count,
  output logic [skbi_pkg::STATUS_W-1:0]           status
);
  import skbi_pkg::*;

  localparam int AW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_INS_CMP, S_INS_PUT, S_Q0, S_QLAST, S_QSCAN,
    S_QDIV, S_MUL, S_ADD, S_FIN
  } state_t;

  state_t state;

  // Latched item.
  logic                    cmd_r;
  logic signed [KEY_W-1:0] key_r;
  logic [DUR_W-1:0]        dur_r;
  logic                    present_r;

  logic [CW-1:0]           cnt;
  logic [CW-1:0]           cnt_m1;
  logic [AW-1:0]           j;
  logic [AW-1:0]           m;
  entry_t                  prev;

  // Working result.
  logic [AW-1:0]           lo_i;
  logic [AW-1:0]           hi_i;
  logic [DUR_W-1:0]        dl;
  logic [DUR_W-1:0]        dh;
  logic [FRAC_W-1:0]       frac;
  logic [DUR_W-1:0]        bdur;
  logic [STATUS_W-1:0]     st;
  logic signed [33:0]      prod;
  logic signed [16:0]      ddiff;
  logic signed [33:0]      sum;

  // Memory and divider hookup.
  logic                    mem_we;
  logic [AW-1:0]           mem_wa;
  entry_t                  mem_wd;
  logic [AW-1:0]           mem_ra;
  entry_t                  rdata;
  logic signed [KEY_W-1:0] rkey;
  entry_t                  new_entry;
  div_req_t                div_req;
  logic                    div_done;
  logic [FRAC_W-1:0]       div_quot;
  logic signed [KEY_W:0]   span_w;
  logic signed [KEY_W:0]   num_w;
  logic                    found;

  logic [AW+IDX_OUT_W-1:0] lo_ext;
  logic [AW+IDX_OUT_W-1:0] hi_ext;
  logic [CW+CNT_OUT_W-1:0] cnt_ext;

  skbi_mem #(.DEPTH(SLOTS), .AW(AW)) u_mem (
    .clk (clk),
    .we  (mem_we),
    .wa  (mem_wa),
    .wd  (mem_wd),
    .ra  (mem_ra),
    .rd  (rdata)
  );

  skbi_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .done (div_done),
    .quot (div_quot)
  );

  assign in_stall  = (state != S_IDLE);
  assign cnt_m1    = cnt - CW'(1);
  assign rkey      = rdata.key;
  assign new_entry = '{key: key_r, dur: dur_r};
  assign found     = key_r <= rkey;
  assign span_w    = $signed({rkey[KEY_W-1], rkey}) - $signed({prev.key[KEY_W-1], prev.key});
  assign num_w     = $signed({key_r[KEY_W-1], key_r})
                   - $signed({prev.key[KEY_W-1], prev.key});
  assign ddiff     = $signed({1'b0, dh}) - $signed({1'b0, dl});
  assign sum       = $signed({2'b00, dl, 16'h0000}) + prod + $signed(34'd32768);
  assign lo_ext    = {{IDX_OUT_W{1'b0}}, lo_i};
  assign hi_ext    = {{IDX_OUT_W{1'b0}}, hi_i};
  assign cnt_ext   = {{CNT_OUT_W{1'b0}}, cnt};

  always_comb begin
    div_req.start = (state == S_QSCAN) && found;
    div_req.num   = num_w[FRAC_W-1:0];
    div_req.den   = span_w[FRAC_W-1:0];
  end

  // Memory port control. A write and a read whose data is used never touch the same
  // entry in the same cycle, and the next item's first read comes after the last write.
  always_comb begin
    mem_we = 1'b0;
    mem_wa = j;
    mem_wd = new_entry;
    mem_ra = '0;
    case (state)
      S_DISP: begin
        if (cmd_r == CMD_INSERT && present_r && cnt != CW'(SLOTS)) begin
          if (cnt == '0) begin
            mem_we = 1'b1;
            mem_wa = '0;
          end else begin
            mem_ra = cnt_m1[AW-1:0];
          end
        end
      end
      S_INS_CMP: begin
        mem_we = 1'b1;
        if (rkey >= key_r) begin
          mem_wd = rdata;
          mem_ra = j - AW'(2);
        end
      end
      S_INS_PUT: begin
        mem_we = 1'b1;
      end
      S_Q0: begin
        mem_ra = cnt_m1[AW-1:0];
      end
      S_QLAST: begin
        mem_ra = AW'(1);
      end
      S_QSCAN: begin
        mem_ra = m + AW'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      // S_FIN reloads the output register itself, so it is cleared here only
      // in the other states.
      if (out_valid && !out_stall && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd_r     <= command;
            key_r     <= key;
            dur_r     <= sample_duration;
            present_r <= sample_present;
            state     <= S_DISP;
          end
        end
        S_DISP: begin
          lo_i <= '0;
          hi_i <= '0;
          frac <= '0;
          bdur <= '0;
          if (cmd_r == CMD_INSERT) begin
            if (!present_r) begin
              st    <= ST_IGNORED;
              state <= S_FIN;
            end else if (cnt == CW'(SLOTS)) begin
              st    <= ST_FULL_DROP;
              state <= S_FIN;
            end else if (cnt == '0) begin
              cnt   <= CW'(1);
              st    <= ST_INSERTED;
              state <= S_FIN;
            end else begin
              j     <= cnt[AW-1:0];
              st    <= ST_INSERTED;
              state <= S_INS_CMP;
            end
          end else begin
            st    <= ST_QUERY_DONE;
            state <= (cnt == '0) ? S_FIN : S_Q0;
          end
        end
        S_INS_CMP: begin
          // Entries whose key is not less than the new one move up by one.
          if (rkey < key_r) begin
            cnt   <= cnt + CW'(1);
            state <= S_FIN;
          end else if (j == AW'(1)) begin
            j     <= '0;
            state <= S_INS_PUT;
          end else begin
            j <= j - AW'(1);
          end
        end
        S_INS_PUT: begin
          cnt   <= cnt + CW'(1);
          state <= S_FIN;
        end
        S_Q0: begin
          if (cnt == CW'(1) || key_r <= rkey) begin
            dl    <= rdata.dur;
            dh    <= rdata.dur;
            state <= S_MUL;
          end else begin
            prev  <= rdata;
            state <= S_QLAST;
          end
        end
        S_QLAST: begin
          if (key_r >= rkey) begin
            lo_i  <= cnt_m1[AW-1:0];
            hi_i  <= cnt_m1[AW-1:0];
            dl    <= rdata.dur;
            dh    <= rdata.dur;
            state <= S_MUL;
          end else begin
            m     <= AW'(1);
            state <= S_QSCAN;
          end
        end
        S_QSCAN: begin
          if (found) begin
            lo_i  <= m - AW'(1);
            hi_i  <= m;
            dl    <= prev.dur;
            dh    <= rdata.dur;
            state <= S_QDIV;
          end else begin
            prev <= rdata;
            m    <= m + AW'(1);
          end
        end
        S_QDIV: begin
          if (div_done) begin
            frac  <= div_quot;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          // dl*(1-f) + dh*f is formed as dl + (dh-dl)*f.
          prod  <= ddiff * $signed({1'b0, frac});
          state <= S_ADD;
        end
        S_ADD: begin
          bdur  <= sum[31:16];
          state <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || !out_stall) begin
            index_low        <= lo_ext[IDX_OUT_W-1:0];
            index_high       <= hi_ext[IDX_OUT_W-1:0];
            fraction         <= frac;
            blended_duration <= bdur;
            entry_count      <= cnt_ext[CNT_OUT_W-1:0];
            status           <= st;
            out_valid        <= 1'b1;
            state            <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `SKBI_ASSERT(a_cnt_bound, cnt <= CW'(SLOTS), "entry count above table size")
  `SKBI_ASSERT(a_busy_after_accept, (in_valid && !in_stall) |=> in_stall, "no stall after accept")
  `SKBI_ASSERT(a_shift_index, (state == S_INS_CMP) |-> (j != '0), "shift index reached zero")
  `SKBI_ASSERT(a_div_done_state, div_done |-> (state == S_QDIV), "divider done outside wait")

endmodule
`default_nettype wire

/* dv/tb_sorted_key_bracket_interpolator.sv */
// Self-checking testbench for sorted_key_bracket_interpolator: a built-in table predictor,
// directed corner cases, a random fill and four random traffic phases with idling and stalls.
// Depends on skbi_pkg and the block's RTL only.
module tb_sorted_key_bracket_interpolator;
  import skbi_pkg::*;

  localparam int SLOTS          = 16;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 80;
  localparam int PHASE_ITEMS    = 160;

  typedef struct packed {
    logic [IDX_OUT_W-1:0] lo;
    logic [IDX_OUT_W-1:0] hi;
    logic [FRAC_W-1:0]    frac;
    logic [DUR_W-1:0]     dur;
    logic [CNT_OUT_W-1:0] count;
    logic [STATUS_W-1:0]  status;
  } bracket_t;

  logic                    clk;
  logic                    rst;
  logic                    in_valid;
  logic                    in_stall;
  logic                    command;
  logic signed [KEY_W-1:0] key;
  logic [DUR_W-1:0]        sample_duration;
  logic                    sample_present;
  logic                    out_valid;
  logic                    out_stall;
  logic [IDX_OUT_W-1:0]    index_low;
  logic [IDX_OUT_W-1:0]    index_high;
  logic [FRAC_W-1:0]       fraction;
  logic [DUR_W-1:0]        blended_duration;
  logic [CNT_OUT_W-1:0]    entry_count;
  logic [STATUS_W-1:0]     status;

  // Predicted table contents, updated when an item is accepted.
  logic signed [KEY_W-1:0] table_keys [SLOTS];
  logic [DUR_W-1:0]        table_durs [SLOTS];
  int                      table_count;

  bracket_t pending_brackets[$];

  int send_idle_pct;
  int recv_stall_pct;
  int mismatch_count;
  int idle_cycles;
  int n_queries;
  int n_interior;
  int n_inserted;
  int n_dropped;
  int n_ignored;
  int n_checked;

  sorted_key_bracket_interpolator #(
    .SLOTS(SLOTS)
  ) u_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .command          (command),
    .key              (key),
    .sample_duration  (sample_duration),
    .sample_present   (sample_present),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .index_low        (index_low),
    .index_high       (index_high),
    .fraction         (fraction),
    .blended_duration (blended_duration),
    .entry_count      (entry_count),
    .status           (status)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Applies one item to the predicted table and returns the result it should give.
  function automatic bracket_t predict_bracket(input logic cmd, input logic signed [KEY_W-1:0] k,
                                               input logic [DUR_W-1:0] d, input logic present);
    bracket_t r;
    int       n;
    int       pos;
    int       kv;
    int       lv;
    int       hv;
    int       frac_v;
    longint   q;
    longint   acc;
    bit       found;
    r      = '0;
    n      = table_count;
    kv     = k;
    found  = 1'b0;
    frac_v = 0;
    if (cmd == CMD_INSERT) begin
      if (!present) begin
        r.status = ST_IGNORED;
      end else if (n >= SLOTS) begin
        r.status = ST_FULL_DROP;
      end else begin
        pos = 0;
        while (pos < n && table_keys[pos] < k) pos++;
        for (int j = n; j > pos; j--) begin
          table_keys[j] = table_keys[j-1];
          table_durs[j] = table_durs[j-1];
        end
        table_keys[pos] = k;
        table_durs[pos] = d;
        n++;
        table_count = n;
        r.status = ST_INSERTED;
      end
    end else begin
      r.status = ST_QUERY_DONE;
      if (n == 0) begin
        r.dur = '0;
      end else if (n == 1 || kv <= table_keys[0]) begin
        r.dur = table_durs[0];
      end else if (kv >= table_keys[n-1]) begin
        r.lo  = IDX_OUT_W'(n - 1);
        r.hi  = IDX_OUT_W'(n - 1);
        r.dur = table_durs[n-1];
      end else begin
        for (int i = 0; i + 1 < n && !found; i++) begin
          lv = table_keys[i];
          hv = table_keys[i+1];
          if (kv >= lv && kv <= hv) begin
            found = 1'b1;
            r.lo  = IDX_OUT_W'(i);
            r.hi  = IDX_OUT_W'(i + 1);
            // A key equal to the upper key gives a full span, which saturates.
            if (hv > lv) begin
              q      = (longint'(kv - lv) << 16) / longint'(hv - lv);
              frac_v = (q > 65535) ? 65535 : int'(q);
            end
            acc    = longint'(table_durs[i]) * (65536 - frac_v)
                   + longint'(table_durs[i+1]) * frac_v + 32768;
            r.frac = FRAC_W'(frac_v);
            r.dur  = acc[31:16];
          end
        end
        if (!found) begin
          r.lo  = IDX_OUT_W'(n - 1);
          r.hi  = IDX_OUT_W'(n - 1);
          r.dur = table_durs[n-1];
        end
      end
    end
    r.count = CNT_OUT_W'(n);
    return r;
  endfunction

  // Query keys aimed at the key extremes, stored keys, their neighbors and the gaps between them, or random.
  function automatic logic signed [KEY_W-1:0] pick_query_key();
    int sel;
    int idx;
    int lv;
    int hv;
    sel = $urandom_range(0, 9);
    if (table_count == 0 || sel == 9) return KEY_W'($urandom);
    if (sel == 0) return 16'sh8000;
    if (sel == 1) return 16'sh7FFF;
    idx = $urandom_range(0, table_count - 1);
    if (sel <= 3) return table_keys[idx];
    if (sel == 4) return table_keys[idx] + ($urandom_range(0, 1) ? 16'sd1 : -16'sd1);
    if (table_count < 2) return KEY_W'($urandom);
    idx = $urandom_range(0, table_count - 2);
    lv  = table_keys[idx];
    hv  = table_keys[idx+1];
    return KEY_W'(lv + int'($urandom_range(0, hv - lv)));
  endfunction

  function automatic logic signed [KEY_W-1:0] pick_insert_key();
    int sel;
    sel = $urandom_range(0, 19);
    if (table_count > 0 && sel < 5) return table_keys[$urandom_range(0, table_count - 1)];
    if (sel == 5) return 16'sh8000;
    if (sel == 6) return 16'sh7FFF;
    return KEY_W'($urandom);
  endfunction

  // Presents one item from a falling edge and holds it until the block takes it.
  task automatic send_item(input logic cmd, input logic signed [KEY_W-1:0] k,
                           input logic [DUR_W-1:0] d, input logic present);
    bracket_t r;
    @(negedge clk);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid        <= 1'b1;
    command         <= cmd;
    key             <= k;
    sample_duration <= d;
    sample_present  <= present;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    r = predict_bracket(cmd, k, d, present);
    pending_brackets.push_back(r);
    case (r.status)
      ST_QUERY_DONE: begin
        n_queries++;
        if (r.lo != r.hi) n_interior++;
      end
      ST_INSERTED:   n_inserted++;
      ST_FULL_DROP:  n_dropped++;
      default:       n_ignored++;
    endcase
  endtask

  task automatic query(input logic signed [KEY_W-1:0] k);
    send_item(CMD_QUERY, k, DUR_W'($urandom), 1'($urandom_range(0, 1)));
  endtask

  task automatic insert(input logic signed [KEY_W-1:0] k, input logic [DUR_W-1:0] d);
    send_item(CMD_INSERT, k, d, 1'b1);
  endtask

  task automatic test_empty_table();
    query(16'sh0000);
    query(16'sh8000);
    query(16'sh7FFF);
    send_item(CMD_INSERT, 16'sh7FFF, 16'hFFFF, 1'b0);
  endtask

  // Single entry, clamps at both ends, interior keys, a duplicate key and an ignored insert.
  task automatic test_small_table();
    insert(16'sh0100, 16'h0200);
    query(16'sh0100);
    query(16'sh8000);
    query(16'sh7FFF);
    insert(16'sh8000, 16'hFFFF);
    insert(16'sh7FFF, 16'h0000);
    query(16'sh0100);
    query(16'sh0000);
    query(16'sh7FFF);
    query(16'sh8000);
    insert(16'sh0100, 16'h1234);
    query(16'sh012C);
    query(16'sh0100);
    query(16'sh00FF);
    query(16'sh7FFE);
    send_item(CMD_INSERT, 16'sh0000, 16'hAAAA, 1'b0);
  endtask

  // Fills the table with random samples mixed with queries, then hits the full case.
  task automatic test_fill_table();
    while (table_count < SLOTS) begin
      if ($urandom_range(0, 9) < 6) insert(pick_insert_key(), DUR_W'($urandom));
      else query(pick_query_key());
    end
    insert(pick_insert_key(), DUR_W'($urandom));
    send_item(CMD_INSERT, pick_insert_key(), DUR_W'($urandom), 1'b0);
    query(pick_query_key());
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct);
    int sel;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (PHASE_ITEMS) begin
      sel = $urandom_range(0, 19);
      if (sel < 15) query(pick_query_key());
      else if (sel < 18) insert(pick_insert_key(), DUR_W'($urandom));
      else send_item(CMD_INSERT, KEY_W'($urandom), DUR_W'($urandom), 1'b0);
    end
  endtask

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Compares every accepted result with the oldest prediction.
  always @(posedge clk) begin
    bracket_t exp_r;
    bracket_t got_r;
    if (!rst && out_valid && !out_stall) begin
      got_r = '{index_low, index_high, fraction, blended_duration, entry_count, status};
      n_checked++;
      if (pending_brackets.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("ERROR: unexpected result lo=%0d hi=%0d frac=%h dur=%h count=%0d status=%0d",
                   got_r.lo, got_r.hi, got_r.frac, got_r.dur, got_r.count, got_r.status);
      end else begin
        exp_r = pending_brackets.pop_front();
        if (got_r !== exp_r) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"ERROR: result %0d expected lo=%0d hi=%0d frac=%h dur=%h count=%0d ",
                      "status=%0d, got lo=%0d hi=%0d frac=%h dur=%h count=%0d status=%0d"},
                     n_checked, exp_r.lo, exp_r.hi, exp_r.frac, exp_r.dur, exp_r.count,
                     exp_r.status, got_r.lo, got_r.hi, got_r.frac, got_r.dur, got_r.count,
                     got_r.status);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("ERROR: no progress for %0d cycles, %0d results outstanding",
               idle_cycles, pending_brackets.size());
      $display("sorted_key_bracket_interpolator regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst             = 1'b1;
    in_valid        = 1'b0;
    command         = CMD_QUERY;
    key             = '0;
    sample_duration = '0;
    sample_present  = 1'b0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    table_count     = 0;
    n_queries       = 0;
    n_interior      = 0;
    n_inserted      = 0;
    n_dropped       = 0;
    n_ignored       = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_table();
    test_small_table();
    test_fill_table();
    test_random_traffic(0, 0);
    test_random_traffic(49, 0);
    test_random_traffic(0, 49);
    test_random_traffic(17, 17);

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_brackets.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d results: %0d queries (%0d between two entries), %0d inserts,",
             n_checked, n_queries, n_interior, n_inserted);
    $display("%0d dropped on a full table, %0d ignored; %0d mismatches",
             n_dropped, n_ignored, mismatch_count);
    if (mismatch_count == 0) begin
      $display("sorted_key_bracket_interpolator regression: pass");
    end else begin
      $display("sorted_key_bracket_interpolator regression: fail");
    end
    $finish;
  end

endmodule
